// ===== rtl/hdp_pkg.sv =====
// Shared types, constants and helper functions for the HTTP Date header parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package hdp_pkg;

	typedef logic [7:0] byte_t;

	localparam int LINE_SIZE_DEF = 64;
	localparam int LEN_W         = 7;
	localparam int KEEP_BYTES    = 31;
	localparam int TAG_LEN       = 6;
	localparam int FIFO_DEPTH    = 2;
	localparam int YEAR_BASE     = 2000;

	localparam byte_t CH_CR   = 8'h0d;
	localparam byte_t CH_LF   = 8'h0a;
	localparam byte_t CH_NUL  = 8'h00;
	localparam byte_t CH_ZERO = 8'h30;
	localparam byte_t CH_NINE = 8'h39;

	localparam logic [47:0] DATE_TAG = "Date: ";

	localparam logic [23:0] MONTH_NAMES [12] = '{
		"Jan", "Feb", "Mar", "Apr", "May", "Jun",
		"Jul", "Aug", "Sep", "Oct", "Nov", "Dec"
	};

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_MONTH = 2'd1,
		ST_FIELD = 2'd2,
		ST_YEAR  = 2'd3
	} status_t;

	// raw bytes of the date fields, positions past the line end read as zero
	typedef struct packed {
		byte_t [1:0] day;
		byte_t [2:0] mon;
		byte_t [1:0] yr;
		byte_t [1:0] hr;
		byte_t [1:0] mi;
		byte_t [1:0] se;
	} job_t;

	function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
		logic [4:0] d;
		begin
			unique case (month)
				4'd2: d = leap ? 5'd29 : 5'd28;
				4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
				default: d = 5'd31;
			endcase
			return d;
		end
	endfunction

	function automatic logic is_digit(input byte_t b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

	function automatic logic [6:0] two_val(input byte_t hi, input byte_t lo);
		return 7'(hi[3:0]) * 7'd10 + 7'(lo[3:0]);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/hdp_front.sv =====
// Front end: accepts bytes, keeps the current line and detects Date lines.
// Depends on hdp_pkg; feeds hdp_fifo.
`default_nettype none

module hdp_front import hdp_pkg::*; #(
	parameter int LINE_SIZE = LINE_SIZE_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  accept,
	input  wire byte_t byte_in,
	output logic       push,
	output job_t       job
);

	logic [LEN_W-1:0] len_q;
	byte_t            line_q [KEEP_BYTES];
	byte_t            masked [KEEP_BYTES];
	logic             prefix_ok;
	logic             is_cr;
	logic             is_lf;

	always_comb begin
		for (int i = 0; i < KEEP_BYTES; i++) begin
			masked[i] = (LEN_W'(i) < len_q) ? line_q[i] : CH_NUL;
		end
		prefix_ok = 1'b1;
		for (int i = 0; i < TAG_LEN; i++) begin
			if (masked[i] != DATE_TAG[8*(TAG_LEN-1-i) +: 8]) begin
				prefix_ok = 1'b0;
			end
		end
		is_cr = (byte_in == CH_CR);
		is_lf = (byte_in == CH_LF);
		push  = accept && is_cr && (len_q > LEN_W'(TAG_LEN)) && prefix_ok;
		job.day = {masked[11], masked[12]};
		job.mon = {masked[14], masked[15], masked[16]};
		job.yr  = {masked[20], masked[21]};
		job.hr  = {masked[23], masked[24]};
		job.mi  = {masked[26], masked[27]};
		job.se  = {masked[29], masked[30]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (accept && (byte_in != CH_NUL) && !is_cr) begin
			if (is_lf) begin
				len_q <= '0;
			end else if (len_q < LEN_W'(LINE_SIZE)) begin
				len_q <= len_q + LEN_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (byte_in != CH_NUL) && !is_cr && !is_lf &&
				(len_q < LEN_W'(KEEP_BYTES))) begin
			line_q[len_q[4:0]] <= byte_in;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/hdp_fifo.sv =====
// Short item queue between front and back end.
// Depends on hdp_pkg for job_t.
`default_nettype none

module hdp_fifo import hdp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t wr_job,
	input  wire logic pop,
	output logic      full,
	output logic      not_empty,
	output job_t      rd_job
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);

	job_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full      = (count_q == (PTR_W+1)'(FIFO_DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_job    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH-1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH-1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/hdp_back.sv =====
// Back end: field decode and checks (s1), hour offset with rollover (s2).
// Depends on hdp_pkg; reads items from hdp_fifo, holds the offset register.
`default_nettype none

module hdp_back import hdp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        tz_we,
	input  wire logic [4:0]  tz_wdata,
	input  wire logic        job_valid,
	input  wire job_t        job,
	output logic             job_pop,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [11:0]      year,
	output logic [3:0]       month,
	output logic [4:0]       day,
	output logic [4:0]       hour,
	output logic [5:0]       minute,
	output logic [5:0]       second,
	output logic [1:0]       status
);

	logic [4:0] tz_q;

	logic       v_s1;
	status_t    st_s1;
	logic [3:0] mon_s1;
	logic [4:0] day_s1;
	logic [6:0] yy_s1;
	logic [4:0] hr_s1;
	logic [5:0] mi_s1;
	logic [5:0] se_s1;

	logic       v_s2;
	status_t    st_s2;
	logic [11:0] year_s2;
	logic [3:0] mon_s2;
	logic [4:0] day_s2;
	logic [4:0] hr_s2;
	logic [5:0] mi_s2;
	logic [5:0] se_s2;

	logic       s1_ready;
	logic       s2_ready;

	// stage 1 decode
	logic [3:0] mon_c;
	logic       digits_ok;
	logic [6:0] day_v, yy_v, hr_v, mi_v, se_v;
	status_t    st_c;

	// stage 2 rollover
	logic signed [6:0] h;
	logic signed [7:0] y;
	logic [3:0] mon_r;
	logic [4:0] day_r;
	status_t    st_r;

	assign s2_ready = !v_s2 || !out_stall;
	assign s1_ready = !v_s1 || s2_ready;
	assign job_pop  = job_valid && s1_ready;

	always_comb begin
		mon_c = '0;
		for (int m = 11; m >= 0; m--) begin
			if ({job.mon[2], job.mon[1], job.mon[0]} == MONTH_NAMES[m]) begin
				mon_c = 4'(m + 1);
			end
		end
		digits_ok = is_digit(job.day[1]) && is_digit(job.day[0]) &&
			is_digit(job.yr[1]) && is_digit(job.yr[0]) &&
			is_digit(job.hr[1]) && is_digit(job.hr[0]) &&
			is_digit(job.mi[1]) && is_digit(job.mi[0]) &&
			is_digit(job.se[1]) && is_digit(job.se[0]);
		day_v = two_val(job.day[1], job.day[0]);
		yy_v  = two_val(job.yr[1], job.yr[0]);
		hr_v  = two_val(job.hr[1], job.hr[0]);
		mi_v  = two_val(job.mi[1], job.mi[0]);
		se_v  = two_val(job.se[1], job.se[0]);
		if (mon_c == '0) begin
			st_c = ST_MONTH;
		end else if (!digits_ok || day_v == '0 ||
				day_v > 7'(days_in(mon_c, yy_v[1:0] == 2'd0)) ||
				hr_v > 7'd23 || mi_v > 7'd59 || se_v > 7'd59) begin
			st_c = ST_FIELD;
		end else begin
			st_c = ST_OK;
		end
	end

	always_comb begin
		h     = $signed({2'b00, hr_s1}) + $signed({{2{tz_q[4]}}, tz_q});
		y     = $signed({1'b0, yy_s1});
		mon_r = mon_s1;
		day_r = day_s1;
		if (h >= 7'sd24) begin
			h = h - 7'sd24;
			if (day_s1 >= days_in(mon_s1, y[1:0] == 2'd0)) begin
				day_r = 5'd1;
				if (mon_s1 == 4'd12) begin
					mon_r = 4'd1;
					y     = y + 8'sd1;
				end else begin
					mon_r = mon_s1 + 4'd1;
				end
			end else begin
				day_r = day_s1 + 5'd1;
			end
		end else if (h < 7'sd0) begin
			h = h + 7'sd24;
			if (day_s1 > 5'd1) begin
				day_r = day_s1 - 5'd1;
			end else begin
				if (mon_s1 > 4'd1) begin
					mon_r = mon_s1 - 4'd1;
				end else begin
					mon_r = 4'd12;
					y     = y - 8'sd1;
				end
				day_r = days_in(mon_r, y[1:0] == 2'd0);
			end
		end
		if (st_s1 != ST_OK) begin
			st_r = st_s1;
		end else if (y < 8'sd0 || y > 8'sd99) begin
			st_r = ST_YEAR;
		end else begin
			st_r = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tz_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (tz_we) begin
				tz_q <= tz_wdata;
			end
			if (s1_ready) begin
				v_s1 <= job_valid;
			end
			if (s2_ready) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			st_s1  <= st_c;
			mon_s1 <= mon_c;
			day_s1 <= day_v[4:0];
			yy_s1  <= yy_v;
			hr_s1  <= hr_v[4:0];
			mi_s1  <= mi_v[5:0];
			se_s1  <= se_v[5:0];
		end
		if (s2_ready && v_s1) begin
			st_s2 <= st_r;
			if (st_r == ST_OK) begin
				year_s2 <= 12'(YEAR_BASE) + 12'(unsigned'(y));
				mon_s2  <= mon_r;
				day_s2  <= day_r;
				hr_s2   <= h[4:0];
				mi_s2   <= mi_s1;
				se_s2   <= se_s1;
			end else begin
				year_s2 <= '0;
				mon_s2  <= '0;
				day_s2  <= '0;
				hr_s2   <= '0;
				mi_s2   <= '0;
				se_s2   <= '0;
			end
		end
	end

	assign out_valid = v_s2;
	assign year      = year_s2;
	assign month     = mon_s2;
	assign day       = day_s2;
	assign hour      = hr_s2;
	assign minute    = mi_s2;
	assign second    = se_s2;
	assign status    = st_s2;

endmodule

`default_nettype wire

// ===== rtl/http_date_header_parser.sv =====
// A carriage return ending a Date line is written to the queue, then registered in stage s1 and in stage s2.
// Throughput: one byte per cycle while in_stall is low; a two-item queue decouples the line front end from decode.
// in_stall rises only while that queue is full (output stalled for several results).
// arst_n clears the line length, the queue, the pipeline valids and the offset (zero).
// Depends on hdp_pkg, hdp_front, hdp_fifo, hdp_back.
`default_nettype none

module http_date_header_parser import hdp_pkg::*; #(
	parameter int LINE_SIZE = LINE_SIZE_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        tz_offset_hours_we,
	input  wire logic signed [4:0] tz_offset_hours,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  byte_in,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [11:0]      year,
	output logic [3:0]       month,
	output logic [4:0]       day,
	output logic [4:0]       hour,
	output logic [5:0]       minute,
	output logic [5:0]       second,
	output logic [1:0]       status
);

	logic accept;
	logic push;
	logic full;
	logic not_empty;
	logic pop;
	job_t wr_job;
	job_t rd_job;

	assign in_stall = full;
	assign accept   = in_valid && !in_stall;

	hdp_front #(
		.LINE_SIZE(LINE_SIZE)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.byte_in (byte_in),
		.push    (push),
		.job     (wr_job)
	);

	hdp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_job    (wr_job),
		.pop       (pop),
		.full      (full),
		.not_empty (not_empty),
		.rd_job    (rd_job)
	);

	hdp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tz_we     (tz_offset_hours_we),
		.tz_wdata  (tz_offset_hours),
		.job_valid (not_empty),
		.job       (rd_job),
		.job_pop   (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.year      (year),
		.month     (month),
		.day       (day),
		.hour      (hour),
		.minute    (minute),
		.second    (second),
		.status    (status)
	);

endmodule

`default_nettype wire

// ===== rtl/hdp_checker.sv =====
// Port-level checks for http_date_header_parser, attached by bind.
// Depends on hdp_pkg for status codes.
`default_nettype none

module hdp_checker import hdp_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic [7:0]  byte_in,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [11:0] year,
	input wire logic [3:0]  month,
	input wire logic [4:0]  day,
	input wire logic [4:0]  hour,
	input wire logic [5:0]  minute,
	input wire logic [5:0]  second,
	input wire logic [1:0]  status
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(year) && $stable(month) &&
			$stable(day) && $stable(hour) && $stable(minute) && $stable(second) &&
			$stable(status))
		else $error("result changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> year == '0 && month == '0 && day == '0 &&
			hour == '0 && minute == '0 && second == '0)
		else $error("error result carries nonzero fields");

	a_ok_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK |-> year >= 12'd2000 && year <= 12'd2099 &&
			month >= 4'd1 && month <= 4'd12 && day >= 5'd1 && hour <= 5'd23 &&
			minute <= 6'd59 && second <= 6'd59)
		else $error("ok result out of range");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(byte_in))
		else $error("input item changed while stalled");

endmodule

bind http_date_header_parser hdp_checker u_hdp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.byte_in   (byte_in),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.year      (year),
	.month     (month),
	.day       (day),
	.hour      (hour),
	.minute    (minute),
	.second    (second),
	.status    (status)
);

`default_nettype wire
